// ===== rtl/core/gde_pkg.sv =====
// gde_pkg: shared types and constants of the grid depth-first explorer
// payload structs, codes and controller/datapath command and status groups
// no dependencies
`default_nettype none

package gde_pkg;

  localparam int unsigned GDE_MAX_W   = 64;
  localparam int unsigned GDE_MAX_H   = 64;
  localparam int unsigned GDE_COORD_W = 6;
  localparam int unsigned GDE_CELLS   = GDE_MAX_W * GDE_MAX_H;
  localparam int unsigned GDE_ADDR_W  = $clog2(GDE_CELLS);
  localparam int unsigned GDE_CNT_W   = GDE_ADDR_W + 1;
  localparam int unsigned GDE_CFG_W   = 7;
  localparam int unsigned GDE_NB_W    = GDE_COORD_W + 2;

  // neighbour offsets in probe order: up, left, right, down
  localparam logic [GDE_NB_W-1:0] GDE_DIR_DX [4] = '{
    GDE_NB_W'(0), {GDE_NB_W{1'b1}}, GDE_NB_W'(1), GDE_NB_W'(0)
  };
  localparam logic [GDE_NB_W-1:0] GDE_DIR_DY [4] = '{
    {GDE_NB_W{1'b1}}, GDE_NB_W'(0), GDE_NB_W'(0), GDE_NB_W'(1)
  };

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_STEP    = 2'd2
  } gde_action_e;

  typedef enum logic [1:0] {
    STAT_ADVANCE   = 2'd0,
    STAT_BACKTRACK = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_ACK       = 2'd3
  } gde_stat_e;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } gde_reg_e;

  typedef enum logic [2:0] {
    RES_ITEM,
    RES_ZERO,
    RES_NBR,
    RES_STACK,
    RES_START
  } gde_res_e;

  typedef enum logic [3:0] {
    S_CLR_BOOT,
    S_IDLE,
    S_DECODE,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_POP_RD,
    S_POP_WB,
    S_CLR_RST,
    S_CLR_EXH,
    S_MARK_RST,
    S_MARK_EXH,
    S_FINISH
  } gde_state_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [GDE_COORD_W-1:0] cell_x;
    logic [GDE_COORD_W-1:0] cell_y;
    logic                   blocked;
  } gde_in_t;

  typedef struct packed {
    logic [GDE_COORD_W-1:0] next_x;
    logic [GDE_COORD_W-1:0] next_y;
    logic [1:0]             status;
  } gde_out_t;

  typedef struct packed {
    logic      load_item;
    logic      blk_we;
    logic      set_start;
    logic      dir_clr;
    logic      dir_inc;
    logic      probe_rd;
    logic      push;
    logic      pop_rd;
    logic      pop_wb;
    logic      clr_step;
    logic      mark_vis;
    logic      init_stack;
    logic      res_load;
    gde_res_e  res_src;
    gde_stat_e res_stat;
    logic      out_load;
  } gde_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       start_in_map;
    logic       cnt_zero;
    logic       cnt_one;
    logic       hit;
    logic       dir_last;
    logic       clr_last;
    logic       out_free;
  } gde_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/gde_datapath.sv =====
// gde_datapath: grid, visited and path memories, cursor registers, result register
// driven by gde_ctrl through gde_pkg::gde_cmd_t; uses gde_pkg
`default_nettype none

module gde_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gde_pkg::gde_in_t             in_data_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output gde_pkg::gde_out_t                 out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [gde_pkg::GDE_CFG_W-1:0] cfg_data_i,
  input  wire gde_pkg::gde_cmd_t            cmd_i,
  output gde_pkg::gde_sts_t                 sts_o
);

  localparam int unsigned CW = gde_pkg::GDE_COORD_W;
  localparam int unsigned AW = gde_pkg::GDE_ADDR_W;
  localparam int unsigned NW = gde_pkg::GDE_CNT_W;
  localparam int unsigned FW = gde_pkg::GDE_CFG_W;
  localparam int unsigned BW = gde_pkg::GDE_NB_W;

  logic                 blk_mem [gde_pkg::GDE_CELLS];
  logic                 vis_mem [gde_pkg::GDE_CELLS];
  logic [2*CW-1:0]      stk_mem [gde_pkg::GDE_CELLS];

  gde_pkg::gde_in_t     item_q;
  logic [FW-1:0]        map_w_q, map_h_q;
  logic [CW-1:0]        top_x_q, top_y_q, start_x_q, start_y_q;
  logic [CW-1:0]        nb_x_q, nb_y_q;
  logic                 nb_in_q;
  logic [NW-1:0]        count_q;
  logic [1:0]           dir_q;
  logic                 blk_rd_q, vis_rd_q;
  logic [2*CW-1:0]      stk_rd_q;
  logic [AW-1:0]        clr_addr_q;
  gde_pkg::gde_out_t    res_q, out_q;
  logic                 out_valid_q;

  logic [FW-1:0]        eff_w, eff_h;
  logic [BW-1:0]        nx, ny;
  logic                 nb_in;
  logic [AW-1:0]        nb_addr, item_addr, start_addr, nbq_addr;
  logic [NW-1:0]        pop_idx;
  logic                 vis_we, vis_wdata;
  logic [AW-1:0]        vis_waddr;
  logic                 stk_we;
  logic [AW-1:0]        stk_waddr;
  logic [2*CW-1:0]      stk_wdata;
  logic                 item_in_store;
  gde_pkg::gde_out_t    res_d;

  // effective map size
  always_comb begin
    if (map_w_q == '0) begin
      eff_w = FW'(1);
    end else if (map_w_q > FW'(gde_pkg::GDE_MAX_W)) begin
      eff_w = FW'(gde_pkg::GDE_MAX_W);
    end else begin
      eff_w = map_w_q;
    end
    if (map_h_q == '0) begin
      eff_h = FW'(1);
    end else if (map_h_q > FW'(gde_pkg::GDE_MAX_H)) begin
      eff_h = FW'(gde_pkg::GDE_MAX_H);
    end else begin
      eff_h = map_h_q;
    end
  end

  // neighbour of the stack top for the current direction
  always_comb begin
    nx    = {2'b00, top_x_q} + gde_pkg::GDE_DIR_DX[dir_q];
    ny    = {2'b00, top_y_q} + gde_pkg::GDE_DIR_DY[dir_q];
    nb_in = !nx[BW-1] && !ny[BW-1] && (nx[FW-1:0] < eff_w) && (ny[FW-1:0] < eff_h);
  end

  assign nb_addr    = {ny[CW-1:0], nx[CW-1:0]};
  assign nbq_addr   = {nb_y_q, nb_x_q};
  assign item_addr  = {item_q.cell_y, item_q.cell_x};
  assign start_addr = {start_y_q, start_x_q};
  assign pop_idx    = count_q - NW'(2);
  assign item_in_store = ({1'b0, item_q.cell_x} < FW'(gde_pkg::GDE_MAX_W)) &&
                         ({1'b0, item_q.cell_y} < FW'(gde_pkg::GDE_MAX_H));

  // visited write port
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_addr_q;
    vis_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd_i.mark_vis) begin
      vis_we    = 1'b1;
      vis_waddr = start_addr;
      vis_wdata = 1'b1;
    end else if (cmd_i.push) begin
      vis_we    = 1'b1;
      vis_waddr = nbq_addr;
      vis_wdata = 1'b1;
    end
  end

  // path stack write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = count_q[AW-1:0];
    stk_wdata = {nb_y_q, nb_x_q};
    if (cmd_i.push) begin
      stk_we = 1'b1;
    end else if (cmd_i.init_stack) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {start_y_q, start_x_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_we && item_in_store) begin
      blk_mem[item_addr] <= item_q.blocked;
    end
    if (cmd_i.probe_rd) begin
      blk_rd_q <= blk_mem[nb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (cmd_i.probe_rd) begin
      vis_rd_q <= vis_mem[nb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd_i.pop_rd) begin
      stk_rd_q <= stk_mem[pop_idx[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.set_start) begin
      start_x_q <= item_q.cell_x;
      start_y_q <= item_q.cell_y;
    end
    if (cmd_i.probe_rd) begin
      nb_x_q  <= nx[CW-1:0];
      nb_y_q  <= ny[CW-1:0];
      nb_in_q <= nb_in;
    end
    if (cmd_i.push) begin
      top_x_q <= nb_x_q;
      top_y_q <= nb_y_q;
    end else if (cmd_i.pop_wb) begin
      top_x_q <= stk_rd_q[CW-1:0];
      top_y_q <= stk_rd_q[2*CW-1:CW];
    end else if (cmd_i.init_stack) begin
      top_x_q <= start_x_q;
      top_y_q <= start_y_q;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.res_stat;
    case (cmd_i.res_src)
      gde_pkg::RES_ITEM: begin
        res_d.next_x = item_q.cell_x;
        res_d.next_y = item_q.cell_y;
      end
      gde_pkg::RES_ZERO: begin
        res_d.next_x = '0;
        res_d.next_y = '0;
      end
      gde_pkg::RES_NBR: begin
        res_d.next_x = nb_x_q;
        res_d.next_y = nb_y_q;
      end
      gde_pkg::RES_STACK: begin
        res_d.next_x = stk_rd_q[CW-1:0];
        res_d.next_y = stk_rd_q[2*CW-1:CW];
      end
      gde_pkg::RES_START: begin
        res_d.next_x = start_x_q;
        res_d.next_y = start_y_q;
      end
      default: begin
        res_d.next_x = '0;
        res_d.next_y = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q     <= FW'(gde_pkg::GDE_MAX_W);
      map_h_q     <= FW'(gde_pkg::GDE_MAX_H);
      count_q     <= '0;
      dir_q       <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gde_pkg::REG_MAP_WIDTH:  map_w_q <= cfg_data_i;
          gde_pkg::REG_MAP_HEIGHT: map_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.push) begin
        count_q <= count_q + NW'(1);
      end else if (cmd_i.pop_rd) begin
        count_q <= count_q - NW'(1);
      end else if (cmd_i.init_stack) begin
        count_q <= NW'(1);
      end
      if (cmd_i.dir_clr) begin
        dir_q <= '0;
      end else if (cmd_i.dir_inc) begin
        dir_q <= dir_q + 2'd1;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.action       = item_q.action;
    sts_o.start_in_map = ({1'b0, item_q.cell_x} < eff_w) && ({1'b0, item_q.cell_y} < eff_h);
    sts_o.cnt_zero     = (count_q == '0);
    sts_o.cnt_one      = (count_q == NW'(1));
    sts_o.hit          = nb_in_q && !blk_rd_q && !vis_rd_q && !count_q[NW-1];
    sts_o.dir_last     = (dir_q == 2'd3);
    sts_o.clr_last     = (clr_addr_q == {AW{1'b1}});
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/gde_ctrl.sv =====
// gde_ctrl: sequencing state machine of the grid depth-first explorer
// issues gde_pkg::gde_cmd_t to gde_datapath and reads gde_pkg::gde_sts_t
`default_nettype none

module gde_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gde_pkg::gde_sts_t sts_i,
  output gde_pkg::gde_cmd_t      cmd_o
);

  gde_pkg::gde_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gde_pkg::S_CLR_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.res_src  = gde_pkg::RES_ITEM;
    cmd_o.res_stat = gde_pkg::STAT_ACK;
    in_ready_o   = 1'b0;
    case (state_q)
      gde_pkg::S_CLR_BOOT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = gde_pkg::S_IDLE;
        end
      end
      gde_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = gde_pkg::S_DECODE;
        end
      end
      gde_pkg::S_DECODE: begin
        case (sts_i.action)
          gde_pkg::ACT_WRITE: begin
            cmd_o.blk_we   = 1'b1;
            cmd_o.res_load = 1'b1;
            state_d = gde_pkg::S_FINISH;
          end
          gde_pkg::ACT_RESTART: begin
            if (sts_i.start_in_map) begin
              cmd_o.set_start = 1'b1;
              state_d = gde_pkg::S_CLR_RST;
            end else begin
              cmd_o.res_load = 1'b1;
              state_d = gde_pkg::S_FINISH;
            end
          end
          default: begin
            if (sts_i.cnt_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_src  = gde_pkg::RES_ZERO;
              state_d = gde_pkg::S_FINISH;
            end else begin
              cmd_o.dir_clr = 1'b1;
              state_d = gde_pkg::S_PROBE_RD;
            end
          end
        endcase
      end
      gde_pkg::S_PROBE_RD: begin
        cmd_o.probe_rd = 1'b1;
        state_d = gde_pkg::S_PROBE_CHK;
      end
      gde_pkg::S_PROBE_CHK: begin
        if (sts_i.hit) begin
          cmd_o.push     = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = gde_pkg::RES_NBR;
          cmd_o.res_stat = gde_pkg::STAT_ADVANCE;
          state_d = gde_pkg::S_FINISH;
        end else if (!sts_i.dir_last) begin
          cmd_o.dir_inc = 1'b1;
          state_d = gde_pkg::S_PROBE_RD;
        end else if (sts_i.cnt_one) begin
          state_d = gde_pkg::S_CLR_EXH;
        end else begin
          state_d = gde_pkg::S_POP_RD;
        end
      end
      gde_pkg::S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d = gde_pkg::S_POP_WB;
      end
      gde_pkg::S_POP_WB: begin
        cmd_o.pop_wb   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = gde_pkg::RES_STACK;
        cmd_o.res_stat = gde_pkg::STAT_BACKTRACK;
        state_d = gde_pkg::S_FINISH;
      end
      gde_pkg::S_CLR_RST: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = gde_pkg::S_MARK_RST;
        end
      end
      gde_pkg::S_CLR_EXH: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = gde_pkg::S_MARK_EXH;
        end
      end
      gde_pkg::S_MARK_RST: begin
        cmd_o.mark_vis   = 1'b1;
        cmd_o.init_stack = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_src    = gde_pkg::RES_START;
        state_d = gde_pkg::S_FINISH;
      end
      gde_pkg::S_MARK_EXH: begin
        cmd_o.mark_vis = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = gde_pkg::RES_START;
        cmd_o.res_stat = gde_pkg::STAT_EXHAUSTED;
        state_d = gde_pkg::S_FINISH;
      end
      gde_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = gde_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gde_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/grid_dfs_explorer_unit.sv =====
// grid_dfs_explorer_unit: top level, one transaction at a time through gde_ctrl and gde_datapath
// depends on gde_pkg, gde_ctrl, gde_datapath
// a write, ack or empty step loads its result directly; a step probes neighbours in turn and a
// backtrack also reads the path stack; restart and exhausted restart first sweep the visited map
// flow: one transaction in flight, the next accepted in the cycle after the result is loaded for output
// reset: visited-map clearing pass over every cell, input not ready until it ends; config taken anytime
`default_nettype none

module grid_dfs_explorer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gde_pkg::gde_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gde_pkg::gde_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_index_i,
  input  wire logic [gde_pkg::GDE_CFG_W-1:0] cfg_data_i
);

  gde_pkg::gde_cmd_t cmd;
  gde_pkg::gde_sts_t sts;

  gde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gde_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for grid_dfs_explorer_unit, directed cases then random exploration
// results are checked against a built-in depth-first search predictor; depends on gde_pkg

module tb;

  localparam int         CW           = gde_pkg::GDE_COORD_W;
  localparam int         FW           = gde_pkg::GDE_CFG_W;
  localparam int         CELLS        = gde_pkg::GDE_CELLS;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 900;
  localparam int         MAX_GAP      = 18;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  gde_pkg::gde_in_t     in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  gde_pkg::gde_out_t    out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [0:0]           cfg_index_i = '0;
  logic [FW-1:0]        cfg_data_i  = '0;

  bit [CELLS-1:0]       wall_map;
  bit [CELLS-1:0]       wall_known;
  bit [CELLS-1:0]       seen_map;
  bit [CW-1:0]          trail_x [CELLS];
  bit [CW-1:0]          trail_y [CELLS];
  int                   trail_depth = 0;
  logic [FW-1:0]        cols_reg    = 7'd64;
  logic [FW-1:0]        rows_reg    = 7'd64;

  gde_pkg::gde_out_t expected_moves [$];
  int       mismatch_cnt = 0;
  int       sent_cnt     = 0;
  bit       gap_quiet    = 1'b0;
  bit       stall_quiet  = 1'b0;

  grid_dfs_explorer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int cols_used();
    if (cols_reg == 0) return 1;
    if (cols_reg > gde_pkg::GDE_MAX_W) return int'(gde_pkg::GDE_MAX_W);
    return int'(cols_reg);
  endfunction

  function automatic int rows_used();
    if (rows_reg == 0) return 1;
    if (rows_reg > gde_pkg::GDE_MAX_H) return int'(gde_pkg::GDE_MAX_H);
    return int'(rows_reg);
  endfunction

  function automatic bit in_grid(int x, int y);
    return x >= 0 && y >= 0 && x < cols_used() && y < rows_used();
  endfunction

  function automatic int cell_addr(int x, int y);
    return y * int'(gde_pkg::GDE_MAX_W) + x;
  endfunction

  // probe order: up, left, right, down
  function automatic void probe_cell(input int x, input int y, input int k,
                                     output int nx, output int ny);
    nx = x;
    ny = y;
    case (k)
      0: ny = y - 1;
      1: nx = x - 1;
      2: nx = x + 1;
      default: ny = y + 1;
    endcase
  endfunction

  function automatic gde_pkg::gde_out_t explore_model(gde_pkg::gde_in_t item);
    gde_pkg::gde_out_t res;
    int       top;
    int       nx;
    int       ny;
    int       a;
    res.next_x = item.cell_x;
    res.next_y = item.cell_y;
    res.status = gde_pkg::STAT_ACK;
    case (item.action)
      gde_pkg::ACT_WRITE: begin
        a = cell_addr(item.cell_x, item.cell_y);
        wall_map[a]   = item.blocked;
        wall_known[a] = 1'b1;
        return res;
      end
      gde_pkg::ACT_RESTART: begin
        if (in_grid(item.cell_x, item.cell_y)) begin
          seen_map    = '0;
          trail_x[0]  = item.cell_x;
          trail_y[0]  = item.cell_y;
          trail_depth = 1;
          seen_map[cell_addr(item.cell_x, item.cell_y)] = 1'b1;
        end
        return res;
      end
      default: ;
    endcase
    if (trail_depth == 0) begin
      res.next_x = '0;
      res.next_y = '0;
      return res;
    end
    top = trail_depth - 1;
    for (int k = 0; k < 4; k++) begin
      probe_cell(trail_x[top], trail_y[top], k, nx, ny);
      if (!in_grid(nx, ny)) continue;
      a = cell_addr(nx, ny);
      if (wall_map[a] || seen_map[a] || trail_depth >= CELLS) continue;
      seen_map[a]          = 1'b1;
      trail_x[trail_depth] = CW'(nx);
      trail_y[trail_depth] = CW'(ny);
      trail_depth++;
      res.next_x = CW'(nx);
      res.next_y = CW'(ny);
      res.status = gde_pkg::STAT_ADVANCE;
      return res;
    end
    if (trail_depth == 1) begin
      seen_map = '0;
      seen_map[cell_addr(trail_x[0], trail_y[0])] = 1'b1;
      res.next_x = trail_x[0];
      res.next_y = trail_y[0];
      res.status = gde_pkg::STAT_EXHAUSTED;
      return res;
    end
    trail_depth--;
    res.next_x = trail_x[trail_depth-1];
    res.next_y = trail_y[trail_depth-1];
    res.status = gde_pkg::STAT_BACKTRACK;
    return res;
  endfunction

  task automatic send_item(logic [1:0] act, int x, int y, bit blk);
    gde_pkg::gde_in_t item;
    int      gap;
    item.action  = act;
    item.cell_x  = CW'(x);
    item.cell_y  = CW'(y);
    item.blocked = blk;
    gap = gap_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    expected_moves.push_back(explore_model(item));
    sent_cnt++;
  endtask

  task automatic wait_results_done();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(gde_pkg::gde_reg_e idx, logic [FW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    if (idx == gde_pkg::REG_MAP_WIDTH) cols_reg = val;
    else rows_reg = val;
  endtask

  task automatic set_map(logic [FW-1:0] w, logic [FW-1:0] h);
    wait_results_done();
    write_reg(gde_pkg::REG_MAP_WIDTH, w);
    write_reg(gde_pkg::REG_MAP_HEIGHT, h);
  endtask

  // load any unknown open/blocked bit around the top cell before stepping
  task automatic step_explorer(logic [1:0] act, int wall_pct);
    int tx;
    int ty;
    int nx;
    int ny;
    if (trail_depth > 0) begin
      tx = trail_x[trail_depth-1];
      ty = trail_y[trail_depth-1];
      for (int k = 0; k < 4; k++) begin
        probe_cell(tx, ty, k, nx, ny);
        if (in_grid(nx, ny) && !wall_known[cell_addr(nx, ny)])
          send_item(gde_pkg::ACT_WRITE, nx, ny, $urandom_range(0, 99) < wall_pct);
      end
    end
    send_item(act, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  task automatic restart_somewhere();
    if ($urandom_range(0, 5) == 0)
      send_item(gde_pkg::ACT_RESTART, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 1));
    else
      send_item(gde_pkg::ACT_RESTART, $urandom_range(0, cols_used() - 1),
                $urandom_range(0, rows_used() - 1), $urandom_range(0, 1));
  endtask

  function automatic logic [FW-1:0] pick_extent();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return FW'($urandom_range(65, 127));
    if (pick < 22) return FW'($urandom_range(9, 64));
    return FW'($urandom_range(1, 8));
  endfunction

  task automatic test_empty_stack();
    send_item(gde_pkg::ACT_STEP, 63, 63, 1'b1);
    send_item(ACT_UNUSED, 0, 0, 1'b0);
  endtask

  task automatic test_single_cell_map();
    set_map(7'd0, 7'd0);
    send_item(gde_pkg::ACT_WRITE, 0, 0, 1'b0);
    send_item(gde_pkg::ACT_RESTART, 0, 0, 1'b0);
    step_explorer(gde_pkg::ACT_STEP, 0);
    send_item(gde_pkg::ACT_RESTART, 1, 0, 1'b1);
    send_item(gde_pkg::ACT_RESTART, 0, 42, 1'b0);
    set_map(7'd1, 7'd1);
    step_explorer(gde_pkg::ACT_STEP, 0);
  endtask

  task automatic test_corner_cells();
    set_map(7'd127, 7'd127);
    send_item(gde_pkg::ACT_WRITE, 63, 63, 1'b1);
    send_item(gde_pkg::ACT_RESTART, 63, 63, 1'b1);
    step_explorer(gde_pkg::ACT_STEP, 50);
    set_map(7'd64, 7'd64);
    send_item(gde_pkg::ACT_RESTART, 0, 0, 1'b0);
    step_explorer(gde_pkg::ACT_STEP, 50);
  endtask

  task automatic test_corridor_backtrack();
    set_map(7'd3, 7'd1);
    for (int x = 0; x < 3; x++) send_item(gde_pkg::ACT_WRITE, x, 0, 1'b0);
    send_item(gde_pkg::ACT_RESTART, 1, 0, 1'b0);
    repeat (5) step_explorer(gde_pkg::ACT_STEP, 0);
  endtask

  task automatic test_random_explore();
    int start_cnt;
    int burst;
    int pick;
    int wall_pct;
    bit held_once;
    start_cnt = sent_cnt;
    held_once = 1'b0;
    while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
      set_map(pick_extent(), pick_extent());
      gap_quiet   = ($urandom_range(0, 4) == 0);
      stall_quiet = ($urandom_range(0, 4) == 0);
      wall_pct    = $urandom_range(5, 45);
      if ($urandom_range(0, 5) != 0) restart_somewhere();
      burst = $urandom_range(15, 60);
      for (int i = 0; i < burst; i++) begin
        if (i == burst / 2 && (!held_once || $urandom_range(0, 3) == 0)) begin
          wait_results_done();
          held_once = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_item(gde_pkg::ACT_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
        else if (pick < 12) restart_somewhere();
        else if (pick < 16) step_explorer(ACT_UNUSED, wall_pct);
        else step_explorer(gde_pkg::ACT_STEP, wall_pct);
      end
    end
    gap_quiet   = 1'b0;
    stall_quiet = 1'b0;
  endtask

  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = stall_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    gde_pkg::gde_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_moves.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] unexpected transaction: x=%0d y=%0d status=%0d", $realtime,
                   out_data_o.next_x, out_data_o.next_y, out_data_o.status);
      end else begin
        want = expected_moves.pop_front();
        if (out_data_o.next_x !== want.next_x || out_data_o.next_y !== want.next_y ||
            out_data_o.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] mismatch: expected x=%0d y=%0d status=%0d, %s",
                     $realtime, want.next_x, want.next_y, want.status,
                     $sformatf("got x=%0d y=%0d status=%0d",
                               out_data_o.next_x, out_data_o.next_y, out_data_o.status));
        end
      end
    end
  end

  initial begin
    #(200_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_stack();
    test_single_cell_map();
    test_corner_cells();
    test_corridor_backtrack();
    test_random_explore();
    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_moves.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gde_pkg.sv
rtl/core/gde_datapath.sv
rtl/core/gde_ctrl.sv
rtl/core/grid_dfs_explorer_unit.sv
tb/sv/tb.sv
